// File: rtl/core/lzbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzbd_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int BYTE_W       = 8;
   localparam int FIELD_BITS   = 8;
   localparam int LEN_BITS     = 4;
   localparam int HAVE_W       = 4;
   localparam int CNT_W        = LEN_BITS + 1;
   localparam logic [WIN_AW-1:0] WP_RESET = WIN_AW'(1);

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_LIT,
      PH_POS,
      PH_LEN
   } phase_type;

   typedef enum logic [1:0] {
      TOK_NONE,
      TOK_LIT,
      TOK_END,
      TOK_COPY
   } tok_type;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } ctl_state_type;

   typedef struct packed {
      phase_type           phase;
      logic [BYTE_W-1:0]   partial;
      logic [HAVE_W-1:0]   have;
      logic [WIN_AW-1:0]   match_pos;
   } parse_state_type;

   typedef struct packed {
      parse_state_type     nxt;
      tok_type             tok;
      logic [BYTE_W-1:0]   value;
      logic [LEN_BITS-1:0] len;
   } parse_result_type;

   typedef struct packed {
      logic accept;
      logic copy_step;
   } ctl_cmd_type;

   typedef struct packed {
      tok_type tok;
      logic    out_free;
      logic    copy_done;
   } dp_status_type;

   localparam parse_state_type PARSE_RESET = '{
      phase: PH_FLAG, partial: '0, have: '0, match_pos: '0};

   // Runs the token parser over all bits of one byte, MSB first.
   // At most one token completes per byte; bits after an end token are dropped.
   function automatic parse_result_type lzbd_parse(parse_state_type st,
                                                   logic [BYTE_W-1:0] din);
      parse_result_type  r;
      logic              stop;
      logic [BYTE_W-1:0] pf;
      r       = '{nxt: st, tok: TOK_NONE, value: '0, len: '0};
      stop    = 1'b0;
      pf      = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (!stop) begin
            if (r.nxt.phase == PH_FLAG) begin
               r.nxt.phase   = din[i] ? PH_LIT : PH_POS;
               r.nxt.partial = '0;
               r.nxt.have    = '0;
            end else begin
               pf            = {r.nxt.partial[BYTE_W-2:0], din[i]};
               r.nxt.partial = pf;
               r.nxt.have    = r.nxt.have + HAVE_W'(1);
               case (r.nxt.phase)
                  PH_LIT: begin
                     if (r.nxt.have == HAVE_W'(FIELD_BITS)) begin
                        r.tok         = TOK_LIT;
                        r.value       = pf;
                        r.nxt.phase   = PH_FLAG;
                        r.nxt.partial = '0;
                        r.nxt.have    = '0;
                     end
                  end
                  PH_POS: begin
                     if (r.nxt.have == HAVE_W'(FIELD_BITS)) begin
                        r.nxt.have = '0;
                        if (pf == '0) begin
                           r.tok       = TOK_END;
                           r.nxt.phase = PH_FLAG;
                           stop        = 1'b1;
                        end else begin
                           r.nxt.match_pos = pf[WIN_AW-1:0];
                           r.nxt.partial   = '0;
                           r.nxt.phase     = PH_LEN;
                        end
                     end
                  end
                  PH_LEN: begin
                     if (r.nxt.have == HAVE_W'(LEN_BITS)) begin
                        r.tok         = TOK_COPY;
                        r.value       = BYTE_W'(r.nxt.match_pos);
                        r.len         = pf[LEN_BITS-1:0];
                        r.nxt.phase   = PH_FLAG;
                        r.nxt.partial = '0;
                        r.nxt.have    = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/lzbd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lzbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lzbd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lzbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       stream_end;
   logic       last;

   modport source (output valid, output out_byte, output stream_end, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input stream_end, input last,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/core/lzbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lzbd_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output lzbd_pkg::ctl_cmd_type  cmd,
   input  lzbd_pkg::dp_status_type status
);
   import lzbd_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.out_free && status.tok == TOK_COPY) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (status.out_free && status.copy_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.copy_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = status.out_free;
            cmd.accept = status.out_free && req_valid;
         end
         ST_COPY: begin
            cmd.copy_step = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/lzbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lzbd_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire [lzbd_pkg::BYTE_W-1:0]       in_byte,
   input  wire                              rsp_ready,
   output logic                             rsp_valid,
   output logic [lzbd_pkg::BYTE_W-1:0]      out_byte,
   output logic                             stream_end,
   output logic                             last,
   input  lzbd_pkg::ctl_cmd_type            cmd,
   output lzbd_pkg::dp_status_type          status
);
   import lzbd_pkg::*;

   parse_state_type   ps_ff;
   parse_state_type   ps_in;
   logic              halted_ff;
   logic              halted_in;
   logic [WIN_AW-1:0] wp_ff;
   logic [WIN_AW-1:0] wp_in;
   logic [WIN_AW-1:0] mp_ff;
   logic [WIN_AW-1:0] mp_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;

   logic [BYTE_W-1:0] mem [WINDOW_DEPTH];
   logic              vld_ff [WINDOW_DEPTH];

   logic [BYTE_W-1:0] rd_ff;
   logic              rd_vld_ff;
   logic              byp_ff;
   logic [BYTE_W-1:0] byp_data_ff;
   logic [BYTE_W-1:0] rd_val;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [BYTE_W-1:0] out_byte_in;
   logic              out_end_ff;
   logic              out_end_in;
   logic              out_last_ff;
   logic              out_last_in;

   parse_result_type  pr;
   tok_type           tok;
   logic              out_free;
   logic              we;
   logic [BYTE_W-1:0] wdata;
   logic              load;

   assign pr       = lzbd_parse(ps_ff, in_byte);
   assign tok      = halted_ff ? TOK_NONE : pr.tok;
   assign out_free = !out_valid_ff || rsp_ready;
   assign rd_val   = byp_ff ? byp_data_ff : (rd_vld_ff ? rd_ff : '0);

   assign status.tok       = tok;
   assign status.out_free  = out_free;
   assign status.copy_done = (cnt_ff == '0);

   assign we    = (cmd.accept && tok == TOK_LIT) || cmd.copy_step;
   assign wdata = cmd.copy_step ? rd_val : pr.value;
   assign load  = (cmd.accept && (tok == TOK_LIT || tok == TOK_END)) || cmd.copy_step;

   always_comb begin
      ps_in        = ps_ff;
      halted_in    = halted_ff;
      wp_in        = we ? wp_ff + WIN_AW'(1) : wp_ff;
      mp_in        = mp_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      if (cmd.accept && !halted_ff) begin
         ps_in = pr.nxt;
         if (tok == TOK_END) begin
            halted_in = 1'b1;
         end
         if (tok == TOK_COPY) begin
            mp_in  = pr.value[WIN_AW-1:0];
            cnt_in = CNT_W'(pr.len) + CNT_W'(1);
         end
      end
      if (cmd.copy_step) begin
         mp_in  = mp_ff + WIN_AW'(1);
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = cmd.copy_step ? rd_val : pr.value;
         out_end_in   = !cmd.copy_step && tok == TOK_END;
         out_last_in  = cmd.copy_step ? (cnt_ff == '0) : 1'b1;
         if (!cmd.copy_step && tok == TOK_END) begin
            out_byte_in = '0;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff        <= PARSE_RESET;
         halted_ff    <= 1'b0;
         wp_ff        <= WP_RESET;
         mp_ff        <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ps_ff        <= ps_in;
         halted_ff    <= halted_in;
         wp_ff        <= wp_in;
         mp_ff        <= mp_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

   // window: one write port, one registered read port at the copy source
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wp_ff] <= wdata;
      end
      rd_ff <= mem[mp_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (we) begin
         vld_ff[wp_ff] <= 1'b1;
      end
   end

   // read-during-write forwarding for overlapping copies
   always_ff @(posedge clock) begin
      rd_vld_ff   <= vld_ff[mp_in];
      byp_ff      <= we && (wp_ff == mp_in);
      byp_data_ff <= wdata;
   end

   assign rsp_valid  = out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign stream_end = out_end_ff;
   assign last       = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/core/lzss_bitstream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Output: a literal or end result appears in the cycle after the byte's beat;
// a match's first copied byte passes the window read register, then the output one.
// A byte with no token end, a literal or the end token is taken with no copy pass;
// a byte that ends a match starts a copy pass of L+2 bytes, set by the window's
// single read port, one copied byte per cycle while the output is free.
// Reset: synchronous, active high; window valid bits clear at once, no clearing pass.
module lzss_bitstream_decoder (
   input  wire              clock,
   input  wire              reset,
   lzbd_req_if.sink         req_ch,
   lzbd_rsp_if.source       rsp_ch
);
   import lzbd_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   lzbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lzbd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_ch.in_byte),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .out_byte   (rsp_ch.out_byte),
      .stream_end (rsp_ch.stream_end),
      .last       (rsp_ch.last),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire
